// ----- rtl/core/jrd_pkg.sv -----
// jrd_pkg: shared types and constants for the radial deadzone block
// no dependencies
package jrd_pkg;

    localparam int OUT_FRAC_BITS = 15;
    localparam logic [14:0] FULL_SCALE = 15'h7fff;
    localparam logic [15:0] A_MASK = 16'h1000;
    localparam logic [14:0] LEFT_DZ_RESET = 15'd7849;
    localparam logic [14:0] RIGHT_DZ_RESET = 15'd8689;
    localparam logic [0:0] REG_LEFT_DZ = 1'b0;
    localparam logic [0:0] REG_RIGHT_DZ = 1'b1;

    // quotient width: value up to 2^16 << frac, keep enough
    localparam int NUM_W = 16 + OUT_FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SQRT, ST_CHECK, ST_DIV, ST_DONE
    } t_lane_state;

    typedef struct packed {
        logic        active;
        logic [15:0] dir_x;
        logic [15:0] dir_y;
        logic [14:0] amount;
    } t_lane_res;

endpackage

// ----- rtl/core/jrd_div.sv -----
// jrd_div: restoring divider, one quotient bit per cycle
// depends on jrd_pkg
module jrd_div
    import jrd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [16:0]      i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    logic [NUM_W-1:0] r_q, n_q;
    logic [16:0]      r_rem, n_rem;
    logic [17:0]      trial;
    logic [16:0]      r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    always_comb begin
        trial = {r_rem, r_q[NUM_W-1]} - {1'b0, r_den};
        if (!trial[17]) begin
            n_rem = trial[16:0];
            n_q   = {r_q[NUM_W-2:0], 1'b1};
        end else begin
            n_rem = {r_rem[15:0], r_q[NUM_W-1]};
            n_q   = {r_q[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_q;
endmodule

// ----- rtl/core/jrd_lane.sv -----
// jrd_lane: one stick: iterative square root, then, outside the deadzone, three divisions on a shared divider
// depends on jrd_pkg, jrd_div
module jrd_lane
    import jrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_x,
    input  logic [15:0] i_y,
    input  logic [14:0] i_dz,
    output logic        o_done,
    output t_lane_res   o_res
);
    t_lane_state r_state, n_state;
    logic [31:0] r_n;
    logic [15:0] r_root;
    logic [3:0]  r_step;
    logic [1:0]  r_sel;
    logic        r_xneg, r_yneg;
    logic [15:0] r_ax, r_ay;
    logic [14:0] r_dz;
    logic [31:0] sq;
    logic [33:0] sq_x, sq_y;
    logic [16:0] ax_w, ay_w;
    logic [33:0] t_rem;
    logic        div_start, div_done;
    logic [NUM_W-1:0] div_num, div_q;
    logic [16:0] div_den;
    logic [1:0]  div_sel;
    logic [14:0] cl;
    logic [15:0] dq;

    assign ax_w = i_x[15] ? 17'(-$signed({i_x[15], i_x})) : {1'b0, i_x};
    assign ay_w = i_y[15] ? 17'(-$signed({i_y[15], i_y})) : {1'b0, i_y};
    assign sq_x = ax_w * ax_w;
    assign sq_y = ay_w * ay_w;
    assign sq = sq_x[31:0] + sq_y[31:0];

    // one root bit per cycle: remainder in r_rem2, radicand bits taken from r_n top bits
    logic [33:0] r_rem2;
    logic [35:0] tr;
    always_comb begin
        tr = {r_rem2, r_n[31:30]} - {18'd0, r_root, 2'b01};
        t_rem = tr[33:0];
    end

    assign cl = (r_root > 16'(FULL_SCALE)) ? FULL_SCALE : r_root[14:0];

    // a restart loads the operands of the next division
    assign div_sel = (r_state == ST_DIV && div_done) ? r_sel + 2'd1 : r_sel;

    always_comb begin
        n_state = r_state;
        div_start = 1'b0;
        div_num = '0;
        div_den = {1'b0, r_root};
        unique case (r_state)
            ST_IDLE: if (i_start) n_state = ST_SQRT;
            ST_SQRT: if (r_step == 4'd0) n_state = ST_CHECK;
            // root is complete here, last bit landed on the way in
            ST_CHECK: begin
                if (r_root <= {1'b0, r_dz})
                    n_state = ST_DONE;
                else begin
                    n_state = ST_DIV;
                    div_start = 1'b1;
                end
            end
            ST_DIV: begin end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
        unique case (div_sel)
            2'd0: div_num = NUM_W'({r_ax, {OUT_FRAC_BITS{1'b0}}});
            2'd1: div_num = NUM_W'({r_ay, {OUT_FRAC_BITS{1'b0}}});
            default: begin
                div_num = NUM_W'({cl - r_dz, {OUT_FRAC_BITS{1'b0}}});
                div_den = {2'b0, FULL_SCALE - r_dz};
            end
        endcase
        if (r_state == ST_DIV && div_done && r_sel != 2'd2) div_start = 1'b1;
        if (r_state == ST_DIV && div_done && r_sel == 2'd2) n_state = ST_DONE;
    end

    jrd_div u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_num(div_num),
        .i_den(div_den), .o_done(div_done), .o_quot(div_q)
    );

    assign dq = (div_q > NUM_W'(32767)) ? 16'h7fff : div_q[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= (r_state == ST_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_n    <= sq;
            r_rem2 <= '0;
            r_root <= '0;
            r_step <= 4'd15;
            r_sel  <= 2'd0;
            r_ax   <= ax_w[15:0];
            r_ay   <= ay_w[15:0];
            r_xneg <= i_x[15];
            r_yneg <= i_y[15];
            r_dz   <= i_dz;
            o_res  <= '0;
        end else if (r_state == ST_SQRT) begin
            if (!tr[35]) begin
                r_rem2 <= t_rem;
                r_root <= {r_root[14:0], 1'b1};
            end else begin
                r_rem2 <= {r_rem2[31:0], r_n[31:30]};
                r_root <= {r_root[14:0], 1'b0};
            end
            r_n <= {r_n[29:0], 2'b00};
            if (r_step != 4'd0) r_step <= r_step - 1'b1;
        end else if (r_state == ST_DIV && div_done) begin
            o_res.active <= 1'b1;
            r_sel <= r_sel + 1'b1;
            unique case (r_sel)
                2'd0: o_res.dir_x <= r_xneg ? 16'(-((div_q > NUM_W'(32768)) ? 17'h8000
                                   : {1'b0, div_q[15:0]})) : dq;
                2'd1: o_res.dir_y <= r_yneg ? 16'(-((div_q > NUM_W'(32768)) ? 17'h8000
                                   : {1'b0, div_q[15:0]})) : dq;
                default: o_res.amount <= (r_dz == FULL_SCALE) ? FULL_SCALE
                                   : ((div_q > NUM_W'(32767)) ? FULL_SCALE : div_q[14:0]);
            endcase
        end
    end
endmodule

// ----- rtl/core/joystick_radial_deadzone.sv -----
// joystick_radial_deadzone: top level, two stick lanes and the merge/output register
// depends on jrd_pkg, jrd_lane
//
// channel | dir | handshake           | payload
// in      | in  | i_valid / o_ready   | packet_number, buttons, sticks
// out     | out | o_valid / i_ready   | jump, active, dir, amount per stick
// cfg     | in  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// an active stick goes from accept to result through 16 root steps, one
// deadzone check and three divisions, the two lanes side by side;
// with both sticks inside their deadzones the divisions are skipped;
// one report at a time; a result waits in the output register, next report
// accepted once the result is taken; reset is synchronous, active low
module joystick_radial_deadzone
    import jrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_packet_number,
    input  logic [15:0] i_buttons,
    input  logic [15:0] i_left_x,
    input  logic [15:0] i_left_y,
    input  logic [15:0] i_right_x,
    input  logic [15:0] i_right_y,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_jump,
    output logic        o_left_active,
    output logic [15:0] o_left_dir_x,
    output logic [15:0] o_left_dir_y,
    output logic [14:0] o_left_amount,
    output logic        o_right_active,
    output logic [15:0] o_right_dir_x,
    output logic [15:0] o_right_dir_y,
    output logic [14:0] o_right_amount
);
    logic [14:0] r_ldz, r_rdz;
    logic [31:0] r_last;
    logic        r_busy, r_jump, r_ld, r_rd;
    logic        start, l_done, r_done_w;
    t_lane_res   l_res, r_res;

    assign o_ready     = !r_busy && !o_valid;
    assign o_cfg_ready = 1'b1;
    assign start       = i_valid && o_ready;

    jrd_lane u_left (.i_clk, .i_rst_n, .i_start(start), .i_x(i_left_x), .i_y(i_left_y),
                     .i_dz(r_ldz), .o_done(l_done), .o_res(l_res));
    jrd_lane u_right (.i_clk, .i_rst_n, .i_start(start), .i_x(i_right_x), .i_y(i_right_y),
                      .i_dz(r_rdz), .o_done(r_done_w), .o_res(r_res));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ldz <= LEFT_DZ_RESET;
            r_rdz <= RIGHT_DZ_RESET;
            r_last <= '0;
            r_busy <= 1'b0;
            r_ld <= 1'b0;
            r_rd <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_LEFT_DZ:  r_ldz <= i_cfg_data;
                    REG_RIGHT_DZ: r_rdz <= i_cfg_data;
                    default: ;
                endcase
            end
            if (start) begin
                r_busy <= 1'b1;
                r_jump <= (i_packet_number != r_last) && (i_buttons == A_MASK);
                r_last <= i_packet_number;
                r_ld <= 1'b0;
                r_rd <= 1'b0;
            end else if (r_busy) begin
                // merge: wait for both lanes
                if (l_done) begin
                    r_ld <= 1'b1;
                    {o_left_active, o_left_dir_x, o_left_dir_y, o_left_amount} <= l_res;
                end
                if (r_done_w) begin
                    r_rd <= 1'b1;
                    {o_right_active, o_right_dir_x, o_right_dir_y, o_right_amount} <= r_res;
                end
                if ((r_ld || l_done) && (r_rd || r_done_w)) begin
                    r_busy <= 1'b0;
                    o_valid <= 1'b1;
                    o_jump <= r_jump;
                end
            end
            if (o_valid && i_ready) o_valid <= 1'b0;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(o_valid && r_busy))
        else $error("result shown while lanes busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) start |=> r_busy)
        else $error("lanes not started");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid && !i_ready |=> o_valid)
        else $error("result dropped");
endmodule
